// ===== hw/rtl/at_response_parser_macros.svh =====
// Assertion macros shared by the reply parser RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef AT_RESPONSE_PARSER_MACROS_SVH
`define AT_RESPONSE_PARSER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ATRP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ATRP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/atrp_pkg.sv =====
// Shared types, limits and codes of the AT reply parser.
// No dependencies; used by every RTL file of the block.
package atrp_pkg;

    // Limits of the reply text.
    localparam int MAX_LINES = 16;
    localparam int LINE_LEN  = 128;

    localparam int LINES_W = $clog2(MAX_LINES + 1);
    localparam int COL_W   = $clog2(LINE_LEN);

    typedef logic [LINES_W-1:0] lines_t;
    typedef logic [COL_W-1:0]   col_t;

    // Bytes of the reply grammar.
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_O    = 8'h4F;
    localparam logic [7:0] CH_E    = 8'h45;
    localparam logic [7:0] CH_K    = 8'h4B;
    localparam logic [7:0] CH_R    = 8'h52;

    // Command kinds.
    localparam logic [1:0] CMD_OTHER = 2'd0;

    // Status codes.
    localparam logic [1:0] STAT_BUSY    = 2'd0;
    localparam logic [1:0] STAT_SUCCESS = 2'd1;
    localparam logic [1:0] STAT_ERROR   = 2'd2;

    typedef enum logic [4:0] {
        P_START   = 5'd0,
        P_LF1     = 5'd1,
        P_HEAD    = 5'd2,
        P_FIRST   = 5'd3,
        P_TEXT    = 5'd4,
        P_TLF     = 5'd5,
        P_NEXT    = 5'd6,
        P_ELF     = 5'd7,
        P_FINAL   = 5'd8,
        P_OK_K    = 5'd9,
        P_END_CR  = 5'd10,
        P_END_LF  = 5'd11,
        P_ER_R1   = 5'd12,
        P_ER_R2   = 5'd13,
        P_ER_O    = 5'd14,
        P_ER_R3   = 5'd15,
        P_SUCCESS = 5'd16,
        P_ERROR   = 5'd17
    } parser_state_t;

    // One received word.
    typedef struct packed {
        logic [7:0] rx_char;
        logic [1:0] command;
    } item_t;

    // One result word.
    typedef struct packed {
        logic [1:0] parse_status;
        logic       response_ok;
        logic [4:0] info_lines;
        logic       text_valid;
        logic [7:0] text_char;
        logic [3:0] text_line;
        logic [6:0] text_column;
        logic       line_done;
        logic       overflow;
    } result_t;

    function automatic logic [4:0] count_field(input lines_t v);
        logic [31:0] w;
        w = 32'(v);
        return w[4:0];
    endfunction

    function automatic logic [3:0] line_field(input lines_t v);
        logic [31:0] w;
        w = 32'(v);
        return w[3:0];
    endfunction

    function automatic logic [6:0] col_field(input col_t v);
        logic [31:0] w;
        w = 32'(v);
        return w[6:0];
    endfunction

endpackage

// ===== hw/rtl/at_response_parser.sv =====
// Top level of the AT reply parser: input register, grammar machine, result register.
// Depends on atrp_pkg, atrp_in_reg, atrp_fsm and at_response_parser_macros.svh.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------------
//  in      | in_valid / in_ready  | rx_char, command
//  out     | out_valid / out_ready| parse_status, response_ok, info_lines,
//          |                      | text_valid, text_char, text_line, text_column,
//          |                      | line_done, overflow
//
// Each received word yields exactly one result word. A taken word waits in the input
// register, then passes the grammar machine into the result register, which offers it
// with out_valid. A new word is taken every cycle while the output does not stall.
// Reset returns the machine to the start of a reply with all counts cleared. A stalled
// output holds its word while one more word waits in the input register; only then
// does in_ready fall.
`include "at_response_parser_macros.svh"

module at_response_parser (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_char,
    input  logic [1:0] command,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] parse_status,
    output logic       response_ok,
    output logic [4:0] info_lines,
    output logic       text_valid,
    output logic [7:0] text_char,
    output logic [3:0] text_line,
    output logic [6:0] text_column,
    output logic       line_done,
    output logic       overflow
);

    atrp_pkg::item_t   in_item;
    atrp_pkg::item_t   held_item;
    logic              held_valid;
    logic              advance;
    atrp_pkg::result_t result;
    atrp_pkg::result_t result_reg;
    logic              out_valid_reg;
    logic              out_valid_next;

    assign in_item.rx_char = rx_char;
    assign in_item.command = command;

    // The held word moves into the result register whenever that register is
    // empty or is being emptied in this cycle.
    assign advance = held_valid && (!out_valid_reg || out_ready);

    atrp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .take       (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    atrp_fsm u_fsm (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (held_item),
        .result (result)
    );

    assign out_valid_next = advance ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign parse_status = result_reg.parse_status;
    assign response_ok  = result_reg.response_ok;
    assign info_lines   = result_reg.info_lines;
    assign text_valid   = result_reg.text_valid;
    assign text_char    = result_reg.text_char;
    assign text_line    = result_reg.text_line;
    assign text_column  = result_reg.text_column;
    assign line_done    = result_reg.line_done;
    assign overflow     = result_reg.overflow;

    // A byte is either kept as text or dropped at a limit, never both.
    `ATRP_ASSERT_NOW(a_text_or_drop, out_valid, !(text_valid && overflow),
                     "text byte both kept and dropped")

    // Text right after a line break starts a fresh line at column zero.
    `ATRP_ASSERT_NOW(a_new_line_col, out_valid && line_done && text_valid,
                     text_column == 7'd0, "new line text not at column zero")

    // A word waiting in the input register is not lost while the output stalls.
    `ATRP_ASSERT_NEXT(a_held_kept, held_valid && !advance, held_valid, "waiting input word lost")

endmodule

// ===== hw/rtl/atrp_in_reg.sv =====
// Input register of the AT reply parser: holds one received word.
// Depends on atrp_pkg.
module atrp_in_reg (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  atrp_pkg::item_t in_item,
    input  logic           take,
    output logic           held_valid,
    output atrp_pkg::item_t held_item
);

    logic            valid_reg;
    logic            valid_next;
    atrp_pkg::item_t item_reg;

    // The register refills in the same cycle that its word moves on.
    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

// ===== hw/rtl/atrp_fsm.sv =====
// Reply grammar state machine with line and column counters.
// Depends on atrp_pkg. Updates its state only when step is high.
module atrp_fsm (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  atrp_pkg::item_t   item,
    output atrp_pkg::result_t result
);

    atrp_pkg::parser_state_t state_reg;
    atrp_pkg::parser_state_t state_next;
    atrp_pkg::parser_state_t cur;
    atrp_pkg::lines_t        lines_reg;
    atrp_pkg::lines_t        lines_next;
    atrp_pkg::col_t          col_reg;
    atrp_pkg::col_t          col_next;
    logic                    ok_reg;
    logic                    ok_next;

    logic [7:0] c;
    logic       ident;
    logic       emit_req;
    logic       at_limit;
    logic       done;
    atrp_pkg::lines_t lines_base;
    atrp_pkg::col_t   col_base;

    assign c     = item.rx_char;
    assign ident = (item.command != atrp_pkg::CMD_OTHER);

    // A finished reply restarts the grammar on the next word.
    assign cur = (state_reg == atrp_pkg::P_SUCCESS || state_reg == atrp_pkg::P_ERROR)
                 ? atrp_pkg::P_START : state_reg;

    always_comb
    begin
        unique case (cur)
            atrp_pkg::P_START:
                state_next = (c == atrp_pkg::CH_CR) ? atrp_pkg::P_LF1 : atrp_pkg::P_ERROR;
            atrp_pkg::P_LF1:
                state_next = (c == atrp_pkg::CH_LF) ? atrp_pkg::P_HEAD : atrp_pkg::P_ERROR;
            atrp_pkg::P_HEAD:
            begin
                if (c == atrp_pkg::CH_PLUS || ident)
                    state_next = atrp_pkg::P_FIRST;
                else if (c == atrp_pkg::CH_O)
                    state_next = atrp_pkg::P_OK_K;
                else if (c == atrp_pkg::CH_E)
                    state_next = atrp_pkg::P_ER_R1;
                else
                    state_next = atrp_pkg::P_ERROR;
            end
            atrp_pkg::P_FIRST:
                state_next = (c == atrp_pkg::CH_CR || c == atrp_pkg::CH_LF)
                             ? atrp_pkg::P_ERROR : atrp_pkg::P_TEXT;
            atrp_pkg::P_TEXT:
            begin
                if (c == atrp_pkg::CH_CR)
                    state_next = atrp_pkg::P_TLF;
                else if (c == atrp_pkg::CH_LF)
                    state_next = atrp_pkg::P_ERROR;
                else
                    state_next = atrp_pkg::P_TEXT;
            end
            atrp_pkg::P_TLF:
                state_next = (c == atrp_pkg::CH_LF) ? atrp_pkg::P_NEXT : atrp_pkg::P_ERROR;
            atrp_pkg::P_NEXT:
            begin
                if (c == atrp_pkg::CH_CR)
                    state_next = atrp_pkg::P_ELF;
                else if (c == atrp_pkg::CH_PLUS)
                    state_next = atrp_pkg::P_FIRST;
                else
                    state_next = atrp_pkg::P_ERROR;
            end
            atrp_pkg::P_ELF:
                state_next = (c == atrp_pkg::CH_LF) ? atrp_pkg::P_FINAL : atrp_pkg::P_ERROR;
            atrp_pkg::P_FINAL:
            begin
                if (c == atrp_pkg::CH_O)
                    state_next = atrp_pkg::P_OK_K;
                else if (c == atrp_pkg::CH_E)
                    state_next = atrp_pkg::P_ER_R1;
                else
                    state_next = atrp_pkg::P_ERROR;
            end
            atrp_pkg::P_OK_K:
                state_next = (c == atrp_pkg::CH_K) ? atrp_pkg::P_END_CR : atrp_pkg::P_ERROR;
            atrp_pkg::P_END_CR:
                state_next = (c == atrp_pkg::CH_CR) ? atrp_pkg::P_END_LF : atrp_pkg::P_ERROR;
            atrp_pkg::P_END_LF:
                state_next = (c == atrp_pkg::CH_LF) ? atrp_pkg::P_SUCCESS : atrp_pkg::P_ERROR;
            atrp_pkg::P_ER_R1:
                state_next = (c == atrp_pkg::CH_R) ? atrp_pkg::P_ER_R2 : atrp_pkg::P_ERROR;
            atrp_pkg::P_ER_R2:
                state_next = (c == atrp_pkg::CH_R) ? atrp_pkg::P_ER_O : atrp_pkg::P_ERROR;
            atrp_pkg::P_ER_O:
                state_next = (c == atrp_pkg::CH_O) ? atrp_pkg::P_ER_R3 : atrp_pkg::P_ERROR;
            atrp_pkg::P_ER_R3:
                state_next = (c == atrp_pkg::CH_R) ? atrp_pkg::P_END_CR : atrp_pkg::P_ERROR;
            default:
                state_next = atrp_pkg::P_ERROR;
        endcase
    end

    // Counters, flag and result word for the current byte.
    always_comb
    begin
        done       = (cur == atrp_pkg::P_NEXT);
        lines_base = lines_reg;
        col_base   = col_reg;
        ok_next    = ok_reg;
        emit_req   = 1'b0;

        if (cur == atrp_pkg::P_START)
        begin
            lines_base = '0;
            col_base   = '0;
            ok_next    = 1'b0;
        end
        if (done)
        begin
            if (lines_reg < atrp_pkg::LINES_W'(atrp_pkg::MAX_LINES))
                lines_base = lines_reg + atrp_pkg::LINES_W'(1);
            col_base = '0;
        end
        if (cur == atrp_pkg::P_OK_K)
            ok_next = 1'b1;
        if (cur == atrp_pkg::P_ER_R3)
            ok_next = 1'b0;

        case (cur)
            atrp_pkg::P_HEAD:  emit_req = (c == atrp_pkg::CH_PLUS) || ident;
            atrp_pkg::P_FIRST: emit_req = (c != atrp_pkg::CH_CR) && (c != atrp_pkg::CH_LF);
            atrp_pkg::P_TEXT:  emit_req = (c != atrp_pkg::CH_CR) && (c != atrp_pkg::CH_LF);
            atrp_pkg::P_NEXT:  emit_req = (c == atrp_pkg::CH_PLUS);
            default:           emit_req = 1'b0;
        endcase

        at_limit = (lines_base >= atrp_pkg::LINES_W'(atrp_pkg::MAX_LINES))
                   || (col_base >= atrp_pkg::COL_W'(atrp_pkg::LINE_LEN - 1));

        lines_next = lines_base;
        col_next   = (emit_req && !at_limit) ? col_base + atrp_pkg::COL_W'(1) : col_base;

        if (state_next == atrp_pkg::P_SUCCESS)
            result.parse_status = atrp_pkg::STAT_SUCCESS;
        else if (state_next == atrp_pkg::P_ERROR)
            result.parse_status = atrp_pkg::STAT_ERROR;
        else
            result.parse_status = atrp_pkg::STAT_BUSY;
        result.response_ok = ok_next;
        result.info_lines  = atrp_pkg::count_field(lines_base);
        result.text_valid  = emit_req && !at_limit;
        result.text_char   = result.text_valid ? c : 8'd0;
        result.text_line   = result.text_valid ? atrp_pkg::line_field(lines_base) : 4'd0;
        result.text_column = result.text_valid ? atrp_pkg::col_field(col_base) : 7'd0;
        result.line_done   = done;
        result.overflow    = emit_req && at_limit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= atrp_pkg::P_START;
            lines_reg <= '0;
            col_reg   <= '0;
            ok_reg    <= 1'b0;
        end
        else if (step)
        begin
            state_reg <= state_next;
            lines_reg <= lines_next;
            col_reg   <= col_next;
            ok_reg    <= ok_next;
        end
    end

endmodule
